/* hdl/epws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epws_pkg
// Shared types, constants and the chip geometry table of the EEPROM page
// write splitter.
// ----------------------------------------------------------------------------
package epws_pkg;

   // Request limits
   localparam int MAX_REQUEST   = 128;
   localparam int ADDRESS_LIMIT = 65536;

   // Bus device address base, pins land in bits 3..1
   localparam logic [7:0] DEV_BASE = 8'hA0;

   // Depth of the job queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Chip sizes, 18 bits wide so 128 KiB fits
   localparam logic [17:0] SIZE_8K   = 18'(8 * 1024);
   localparam logic [17:0] SIZE_64K  = 18'(64 * 1024);
   localparam logic [17:0] SIZE_128K = 18'(128 * 1024);

   localparam logic [17:0] ADDR_LIMIT_W = 18'(ADDRESS_LIMIT);
   localparam logic [7:0]  MAX_REQ_W    = 8'(MAX_REQUEST);

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_BLOCK_ENABLED = 2'd0,
      CSR_CHIP_TYPE     = 2'd1,
      CSR_ADDRESS_PINS  = 2'd2
   } csr_index_type;

   // Chip type codes
   typedef enum logic [2:0] {
      CHIP_NONE        = 3'd0,
      CHIP_4B_8K       = 3'd1,
      CHIP_32B_8K      = 3'd2,
      CHIP_128B_64K_A  = 3'd3,
      CHIP_128B_64K_B  = 3'd4,
      CHIP_256B_128K   = 3'd5
   } chip_type_type;

   typedef struct packed {
      logic        valid;
      logic [8:0]  page;
      logic [17:0] total;
   } chip_geom_type;

   // One checked request as handed from the front to the back
   typedef struct packed {
      logic        err;
      logic        wr;
      logic [7:0]  dev;
      logic [15:0] addr;
      logic [7:0]  size;
      logic [8:0]  page;
   } job_type;

   // One result transaction
   typedef struct packed {
      logic        status;
      logic        is_write;
      logic [7:0]  device_address;
      logic [15:0] chunk_address;
      logic [7:0]  chunk_length;
      logic [7:0]  total_bytes;
      logic        last_chunk;
   } rsp_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_RUN  = 1'b1
   } back_state_type;

   // Page size and total size for a chip type; unknown codes are invalid
   function automatic chip_geom_type chip_geom(input logic [2:0] code);
      chip_geom_type g;
      g = '{valid: 1'b1, page: 9'd4, total: SIZE_8K};
      case (code)
         CHIP_4B_8K:      g = '{valid: 1'b1, page: 9'd4,   total: SIZE_8K};
         CHIP_32B_8K:     g = '{valid: 1'b1, page: 9'd32,  total: SIZE_8K};
         CHIP_128B_64K_A: g = '{valid: 1'b1, page: 9'd128, total: SIZE_64K};
         CHIP_128B_64K_B: g = '{valid: 1'b1, page: 9'd128, total: SIZE_64K};
         CHIP_256B_128K:  g = '{valid: 1'b1, page: 9'd256, total: SIZE_128K};
         default:         g = '{valid: 1'b0, page: 9'd4,   total: SIZE_8K};
      endcase
      return g;
   endfunction

endpackage

/* hdl/eeprom_page_write_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeprom_page_write_splitter
// Plans the bus transactions of serial EEPROM reads and writes.
// ----------------------------------------------------------------------------
// A request is checked in the cycle it is taken (enable, chip type, length,
// address range, clipping to the chip end) and queued as a job; a two-entry
// job queue lets the checker keep taking requests while results drain. The
// chunk generator then issues one result per cycle while the output register
// can take it: one result for a read or a rejected request, one per page
// segment for a write, at most 33 for a 128-byte write on a 4-byte-page part.
// An idle generator first takes a job and then issues its results; a job
// already waiting is taken in the cycle of the previous final result. The
// one-result-per-cycle chunk generator sets the sustained rate while results
// are popped. Results pass through the job queue, the generator's job
// registers and an output register.
// Configuration writes take effect on the next cycle and must only be made
// while no request is in flight.
// ----------------------------------------------------------------------------
module eeprom_page_write_splitter (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [2:0]   csr_write_data,
   // requests
   input  logic         push,
   output logic         full,
   input  logic         req_func,
   input  logic [16:0]  req_start_address,
   input  logic [7:0]   req_byte_count,
   // results
   output logic         empty,
   input  logic         pop,
   output logic         rsp_status,
   output logic         rsp_is_write,
   output logic [7:0]   rsp_device_address,
   output logic [15:0]  rsp_chunk_address,
   output logic [7:0]   rsp_chunk_length,
   output logic [7:0]   rsp_total_bytes,
   output logic         rsp_last_chunk
);

   epws_pkg::job_type new_job;
   epws_pkg::job_type head_job;
   epws_pkg::rsp_type rsp;
   logic              job_avail;
   logic              job_take;
   logic              rsp_valid;

   // Check requests
   epws_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_func          (req_func),
      .req_start_address (req_start_address),
      .req_byte_count    (req_byte_count),
      .job               (new_job)
   );

   // Queue checked jobs
   epws_job_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (push),
      .wr_job (new_job),
      .full   (full),
      .rd_en  (job_take),
      .rd_job (head_job),
      .avail  (job_avail)
   );

   // Split jobs into transactions
   epws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_avail (job_avail),
      .job       (head_job),
      .job_take  (job_take),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_pop   (pop)
   );

   assign empty              = !rsp_valid;
   assign rsp_status         = rsp.status;
   assign rsp_is_write       = rsp.is_write;
   assign rsp_device_address = rsp.device_address;
   assign rsp_chunk_address  = rsp.chunk_address;
   assign rsp_chunk_length   = rsp.chunk_length;
   assign rsp_total_bytes    = rsp.total_bytes;
   assign rsp_last_chunk     = rsp.last_chunk;

endmodule

/* hdl/epws_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epws_front
// Holds the configuration registers and checks each request: enable, chip
// type, length, range. Emits one job per request, flagged when rejected.
// ----------------------------------------------------------------------------
module epws_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [2:0]          csr_write_data,
   input  logic                req_func,
   input  logic [16:0]         req_start_address,
   input  logic [7:0]          req_byte_count,
   output epws_pkg::job_type   job
);

   logic       block_enabled_ff, block_enabled_in;
   logic [2:0] chip_type_ff, chip_type_in;
   logic [2:0] address_pins_ff, address_pins_in;

   epws_pkg::chip_geom_type geom;
   logic [7:0]  size_sat;
   logic [7:0]  size_clip;
   logic [17:0] addr_ext;
   logic [17:0] end_raw;
   logic [17:0] end_clip;
   logic [17:0] room_to_end;
   logic        pass_basic;
   logic        pass_all;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      block_enabled_in = block_enabled_ff;
      chip_type_in     = chip_type_ff;
      address_pins_in  = address_pins_ff;
      if (csr_write_enable) begin
         case (csr_index)
            epws_pkg::CSR_BLOCK_ENABLED: block_enabled_in = csr_write_data[0];
            epws_pkg::CSR_CHIP_TYPE:     chip_type_in     = csr_write_data;
            epws_pkg::CSR_ADDRESS_PINS:  address_pins_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_enabled_ff <= 1'b0;
         chip_type_ff     <= epws_pkg::CHIP_4B_8K;
         address_pins_ff  <= 3'd0;
      end else begin
         block_enabled_ff <= block_enabled_in;
         chip_type_ff     <= chip_type_in;
         address_pins_ff  <= address_pins_in;
      end
   end

   // Saturate, check, clip to the chip end, then check the address limit
   always_comb begin
      geom        = epws_pkg::chip_geom(chip_type_ff);
      size_sat    = (req_byte_count > epws_pkg::MAX_REQ_W) ? epws_pkg::MAX_REQ_W
                                                           : req_byte_count;
      addr_ext    = {1'b0, req_start_address};
      end_raw     = addr_ext + {10'd0, size_sat};
      pass_basic  = block_enabled_ff && geom.valid && (size_sat != 8'd0) &&
                    (addr_ext < geom.total);
      room_to_end = geom.total - addr_ext;
      size_clip   = (end_raw > geom.total) ? room_to_end[7:0] : size_sat;
      end_clip    = addr_ext + {10'd0, size_clip};
      pass_all    = pass_basic && !(addr_ext > epws_pkg::ADDR_LIMIT_W) &&
                    !(end_clip > epws_pkg::ADDR_LIMIT_W);

      job.err  = !pass_all;
      job.wr   = req_func;
      job.dev  = epws_pkg::DEV_BASE | {4'd0, address_pins_ff, 1'b0};
      job.addr = req_start_address[15:0];
      job.size = size_clip;
      job.page = geom.page;
   end

endmodule

/* hdl/epws_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epws_job_queue
// Short first-in first-out queue of checked jobs between front and back.
// ----------------------------------------------------------------------------
module epws_job_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  epws_pkg::job_type   wr_job,
   output logic                full,
   input  logic                rd_en,
   output epws_pkg::job_type   rd_job,
   output logic                avail
);

   localparam int PW = epws_pkg::QUEUE_PTR_W;
   localparam int CW = epws_pkg::QUEUE_CNT_W;
   localparam logic [PW-1:0] LAST_PTR = PW'(epws_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(epws_pkg::QUEUE_DEPTH);

   epws_pkg::job_type entry_ff [epws_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign full   = (count_ff == DEPTH_CNT);
   assign avail  = (count_ff != '0);
   assign rd_job = entry_ff[rd_ptr_ff];
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && avail;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

/* hdl/epws_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epws_back
// Carries out one job at a time into a one-entry output register, one
// result per cycle unless the output stalls; writes split at page boundaries.
// ----------------------------------------------------------------------------
module epws_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_avail,
   input  epws_pkg::job_type   job,
   output logic                job_take,
   output epws_pkg::rsp_type   rsp,
   output logic                rsp_valid,
   input  logic                rsp_pop
);

   epws_pkg::back_state_type state_ff, state_in;
   epws_pkg::job_type        cur_ff, cur_in;
   logic [15:0]              addr_ff, addr_in;
   logic [7:0]               left_ff, left_in;
   epws_pkg::rsp_type        out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   epws_pkg::rsp_type chunk;
   logic [8:0] page_off;
   logic [8:0] room;
   logic [7:0] page_mask;
   logic [7:0] len;
   logic       last;
   logic       out_ready;
   logic       emit;

   // Work out the next transaction of the current job
   always_comb begin
      page_mask = 8'(cur_ff.page - 9'd1);
      page_off  = {1'b0, addr_ff[7:0] & page_mask};
      room      = cur_ff.page - page_off;
      if (cur_ff.err) begin
         len  = 8'd0;
         last = 1'b1;
      end else if (!cur_ff.wr) begin
         len  = left_ff;
         last = 1'b1;
      end else begin
         len  = ({1'b0, left_ff} < room) ? left_ff : room[7:0];
         last = (left_ff == len);
      end
      chunk.status         = cur_ff.err;
      chunk.is_write       = cur_ff.wr;
      chunk.device_address = cur_ff.dev;
      chunk.chunk_address  = cur_ff.err ? 16'd0 : addr_ff;
      chunk.chunk_length   = len;
      chunk.total_bytes    = cur_ff.err ? 8'd0 : cur_ff.size;
      chunk.last_chunk     = last;
   end

   // Sequence jobs, load the output register and take the next job
   always_comb begin
      out_ready    = !out_valid_ff || rsp_pop;
      emit         = (state_ff == epws_pkg::BACK_RUN) && out_ready;
      job_take     = job_avail && ((state_ff == epws_pkg::BACK_IDLE) || (emit && last));
      state_in     = state_ff;
      cur_in       = cur_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (emit) begin
         out_in       = chunk;
         out_valid_in = 1'b1;
         addr_in      = addr_ff + {8'd0, len};
         left_in      = left_ff - len;
         if (last) begin
            state_in = epws_pkg::BACK_IDLE;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      if (job_take) begin
         state_in = epws_pkg::BACK_RUN;
         cur_in   = job;
         addr_in  = job.addr;
         left_in  = job.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= epws_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      addr_ff <= addr_in;
      left_ff <= left_in;
      out_ff  <= out_in;
   end

   assign rsp       = out_ff;
   assign rsp_valid = out_valid_ff;

endmodule

/* hdl/epws_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epws_checker
// Port-level checks of the EEPROM page write splitter, bound to the top.
// ----------------------------------------------------------------------------
module epws_checker (
   input logic         clock,
   input logic         reset,
   input logic         empty,
   input logic         pop,
   input logic         rsp_status,
   input logic [15:0]  rsp_chunk_address,
   input logic [7:0]   rsp_chunk_length,
   input logic [7:0]   rsp_total_bytes,
   input logic         rsp_last_chunk
);

   // Reset drops any waiting result
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result visible right after reset");

   // A rejected request gives one final result with zeroed fields
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status) |-> (rsp_last_chunk && rsp_chunk_length == 8'd0 &&
                                  rsp_total_bytes == 8'd0 &&
                                  rsp_chunk_address == 16'd0))
      else $error("rejected result with nonzero fields");

   // A good transaction moves at least one byte and no more than the request
   a_chunk_bounds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_status) |-> (rsp_chunk_length != 8'd0 &&
                                   rsp_chunk_length <= rsp_total_bytes))
      else $error("transaction length out of bounds");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_chunk_address) &&
                            $stable(rsp_chunk_length)))
      else $error("stalled result changed");

endmodule

bind eeprom_page_write_splitter epws_checker u_epws_checker (
   .clock             (clock),
   .reset             (reset),
   .empty             (empty),
   .pop               (pop),
   .rsp_status        (rsp_status),
   .rsp_chunk_address (rsp_chunk_address),
   .rsp_chunk_length  (rsp_chunk_length),
   .rsp_total_bytes   (rsp_total_bytes),
   .rsp_last_chunk    (rsp_last_chunk)
);
